// ----- rtl/smw_pkg.sv -----
package smw_pkg;

   localparam int NUM_THREADS_DEF    = 4;
   localparam int STACK_DEPTH_DEF    = 256;
   localparam int GLOBAL_DEPTH_DEF   = 4096;
   localparam int ADDR_W             = 64;
   localparam int CFG_W              = 3;
   localparam int THREAD_W           = 2;
   localparam logic [CFG_W-1:0] ACTIVE_RESET = 3'd4;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef struct packed {
      logic accept;
      logic check_hit;
      logic steal_init;
      logic spill_step;
      logic steal_step;
      logic steal_end;
   } dp_cmd_type;

   typedef struct packed {
      logic need_spill;
      logic read_done;
      logic read_zero;
      logic item_active;
      logic steal_none;
      logic move_done;
   } dp_status_type;

endpackage

// ----- rtl/smw_datapath.sv -----
module smw_datapath #(
   parameter int NumThreads    = 4,
   parameter int LocalCapacity = 256,
   parameter int GlobalDepth   = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  smw_pkg::dp_cmd_type             cmd,
   output smw_pkg::dp_status_type          status,
   input  logic [smw_pkg::CFG_W-1:0]       active_threads,
   input  logic                            req_command,
   input  logic [smw_pkg::THREAD_W-1:0]    req_thread_index,
   input  logic [smw_pkg::ADDR_W-1:0]      req_address,
   output logic [smw_pkg::ADDR_W-1:0]      res_address,
   output logic                            res_all_empty,
   output logic                            res_dropped
);
   import smw_pkg::*;

   localparam int TW  = (NumThreads > 1) ? $clog2(NumThreads) : 1;
   localparam int CW  = $clog2(LocalCapacity + 2);
   localparam int GW  = (GlobalDepth > 1) ? $clog2(GlobalDepth) : 1;
   localparam int GCW = $clog2(GlobalDepth + 1);
   localparam int MW  = (GCW > CW) ? GCW : CW;
   localparam int LD  = NumThreads * (LocalCapacity + 1);
   localparam int LW  = $clog2(LD);
   localparam logic [CW-1:0]  CAP  = CW'(LocalCapacity);
   localparam logic [CW-1:0]  HALF = CW'(LocalCapacity / 2);
   localparam logic [GCW-1:0] GDEP = GCW'(GlobalDepth);

   logic [ADDR_W-1:0] local_mem [LD];
   logic [ADDR_W-1:0] global_mem [GlobalDepth];

   logic [CW-1:0]  count_ff [NumThreads];
   logic [CW-1:0]  count_in [NumThreads];
   logic [GW-1:0]  head_ff, head_in;
   logic [GCW-1:0] gcount_ff, gcount_in;
   logic [TW-1:0]  thr_ff, thr_in;
   logic [CW-1:0]  c_ff, c_in;
   logic [CW-1:0]  n_ff, n_in;
   logic           act_ff, act_in;
   logic           dropped_ff, dropped_in;
   logic [ADDR_W-1:0] res_ff, res_in;
   logic [ADDR_W-1:0] lrd_ff, grd_ff;
   logic           lrd_valid_ff, grd_valid_ff;

   logic [7:0]    live;
   logic          active;
   logic [TW-1:0] t_sel;
   logic [CW-1:0] c_now;
   logic          l_we, l_re;
   logic [LW-1:0] l_waddr, l_raddr;
   logic [ADDR_W-1:0] l_wdata;
   logic          g_we, g_re;
   logic [GW-1:0] g_waddr, g_raddr;
   logic [GCW:0]  tail_sum;
   logic [MW-1:0] n_pick;
   logic [CW-1:0] n_steal;
   logic          empty_all;

   function automatic logic [LW-1:0] laddr(input logic [TW-1:0] t,
                                           input logic [CW-1:0] c);
      return LW'(t) * LW'(LocalCapacity + 1) + LW'(c);
   endfunction

   always_comb begin
      live = (8'(active_threads) > 8'(NumThreads)) ? 8'(NumThreads)
                                                   : 8'(active_threads);
      t_sel  = TW'(req_thread_index);
      active = (8'(req_thread_index) < live);
      c_now  = (count_ff[t_sel] > CAP) ? CAP : count_ff[t_sel];
      tail_sum = (GCW+1)'(head_ff) + (GCW+1)'(gcount_ff);
      // steal size: smallest of half a stack, the FIFO fill and the free room
      n_pick = MW'(HALF);
      if (MW'(gcount_ff) < n_pick) n_pick = MW'(gcount_ff);
      if (MW'(CAP - c_ff) < n_pick) n_pick = MW'(CAP - c_ff);
      n_steal = CW'(n_pick);
      empty_all = (gcount_ff == '0);
      for (int i = 0; i < NumThreads; i++)
         if (8'(i) < live && count_ff[i] != '0) empty_all = 1'b0;
   end

   always_comb begin
      for (int i = 0; i < NumThreads; i++) count_in[i] = count_ff[i];
      head_in = head_ff;
      gcount_in = gcount_ff;
      thr_in = thr_ff;
      c_in = c_ff;
      n_in = n_ff;
      act_in = act_ff;
      dropped_in = dropped_ff;
      res_in = res_ff;
      l_we = 1'b0; l_re = 1'b0;
      l_waddr = laddr(thr_ff, c_ff);
      l_raddr = laddr(thr_ff, c_ff - CW'(1));
      l_wdata = grd_ff;
      g_we = 1'b0; g_re = 1'b0;
      g_waddr = (tail_sum >= (GCW+1)'(GlobalDepth))
                ? GW'(tail_sum - (GCW+1)'(GlobalDepth)) : GW'(tail_sum);
      g_raddr = head_ff;

      if (cmd.accept) begin
         thr_in = t_sel;
         act_in = active;
         res_in = '0;
         dropped_in = 1'b0;
         n_in = '0;
         c_in = c_now;
         if (active) begin
            if (req_command == CMD_PUSH) begin
               // write at the top; arm a spill of half if now over capacity
               l_we = 1'b1;
               l_waddr = laddr(t_sel, c_now);
               l_wdata = req_address;
               c_in = c_now + CW'(1);
               count_in[t_sel] = c_now + CW'(1);
               if (c_now + CW'(1) > CAP) n_in = (c_now + CW'(1)) >> 1;
            end else if (c_now != '0) begin
               l_re = 1'b1;
               l_raddr = laddr(t_sel, c_now - CW'(1));
               c_in = c_now - CW'(1);
               count_in[t_sel] = c_now - CW'(1);
            end
         end
      end else if (cmd.check_hit) begin
         res_in = lrd_ff;
      end else if (cmd.steal_init) begin
         n_in = n_steal;
      end else if (cmd.spill_step) begin
         // append last cycle's stack word (dropped if the FIFO is full), read the next one
         if (lrd_valid_ff) begin
            if (gcount_ff < GDEP) begin
               g_we = 1'b1;
               gcount_in = gcount_ff + GCW'(1);
            end else begin
               dropped_in = 1'b1;
            end
         end
         if (n_ff != '0) begin
            l_re = 1'b1;
            c_in = c_ff - CW'(1);
            n_in = n_ff - CW'(1);
            count_in[thr_ff] = c_ff - CW'(1);
         end
      end else if (cmd.steal_step) begin
         // push last cycle's FIFO word, read the next one
         if (grd_valid_ff) begin
            l_we = 1'b1;
            res_in = grd_ff;
            c_in = c_ff + CW'(1);
         end
         if (n_ff != '0) begin
            g_re = 1'b1;
            head_in = (head_ff == GW'(GlobalDepth - 1)) ? '0 : head_ff + GW'(1);
            gcount_in = gcount_ff - GCW'(1);
            n_in = n_ff - CW'(1);
         end
      end else if (cmd.steal_end) begin
         // the last stolen word is the one returned
         count_in[thr_ff] = c_ff - CW'(1);
      end
   end

   always_comb begin
      status = '0;
      status.need_spill  = (n_ff != '0);
      status.read_done   = lrd_valid_ff;
      status.read_zero   = (lrd_ff == '0);
      status.item_active = act_ff;
      status.steal_none  = (n_steal == '0);
      status.move_done   = (n_ff == '0) && !lrd_valid_ff && !grd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (l_we) local_mem[l_waddr] <= l_wdata;
      if (l_re) lrd_ff <= local_mem[l_raddr];
      if (g_we) global_mem[g_waddr] <= lrd_ff;
      if (g_re) grd_ff <= global_mem[g_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumThreads; i++) count_ff[i] <= '0;
         head_ff <= '0;
         gcount_ff <= '0;
         thr_ff <= '0;
         c_ff <= '0;
         n_ff <= '0;
         act_ff <= 1'b0;
         dropped_ff <= 1'b0;
         res_ff <= '0;
         lrd_valid_ff <= 1'b0;
         grd_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NumThreads; i++) count_ff[i] <= count_in[i];
         head_ff <= head_in;
         gcount_ff <= gcount_in;
         thr_ff <= thr_in;
         c_ff <= c_in;
         n_ff <= n_in;
         act_ff <= act_in;
         dropped_ff <= dropped_in;
         res_ff <= res_in;
         lrd_valid_ff <= l_re;
         grd_valid_ff <= g_re;
      end
   end

   assign res_address   = res_ff;
   assign res_all_empty = empty_all;
   assign res_dropped   = dropped_ff;

endmodule

// ----- rtl/smw_ctrl.sv -----
module smw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_command,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output smw_pkg::dp_cmd_type     cmd,
   input  smw_pkg::dp_status_type  status
);
   import smw_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_SPILL = 5'b00100,
      S_STEAL = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic pop_ff, pop_in;

   always_comb begin
      state_in = state_ff;
      pop_in = pop_ff;
      cmd = '0;
      req_ready = (state_ff == S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               pop_in = (req_command == CMD_POP);
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!pop_ff) begin
               state_in = status.need_spill ? S_SPILL : S_RESP;
            end else if (!status.item_active) begin
               state_in = S_RESP;
            end else if (status.read_done && !status.read_zero) begin
               cmd.check_hit = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.steal_init = 1'b1;
               state_in = status.steal_none ? S_RESP : S_STEAL;
            end
         end
         S_SPILL: begin
            if (status.move_done) state_in = S_RESP;
            else cmd.spill_step = 1'b1;
         end
         S_STEAL: begin
            if (status.move_done) begin
               cmd.steal_end = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.steal_step = 1'b1;
            end
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pop_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pop_ff <= pop_in;
      end
   end

endmodule

// ----- rtl/split_mark_worklist_core.sv -----
// Split local/global mark worklist.
// Request channel (req_*): one push or pop for one thread's local stack,
// taken when req_valid and req_ready are both high. Response channel (rsp_*):
// exactly one transaction per request, held until rsp_ready is high.
// Configuration (csr_*): active_threads, always ready; write it only while no
// request is in flight. One request is in flight at a time; req_ready is low
// from acceptance until the response has been taken.
// Paths from acceptance to the response:
//  - plain push, pop that hits, inactive thread, or nothing to steal: goes
//    from the check state straight to the response state.
//  - push that overfills a stack: (LocalCapacity+1)/2 words spill one a cycle
//    through the stack read port into the FIFO, then the response.
//  - pop on an empty stack or a null word: up to LocalCapacity/2 words are
//    stolen one a cycle through the FIFO read port, then the response.
// Reset clears the stack counts, FIFO head and count and sets active_threads
// to 4; store contents need no clearing, only written entries are read.
// A stalled receiver holds the response and blocks the next request.
module split_mark_worklist_core #(
   parameter int NumThreads    = smw_pkg::NUM_THREADS_DEF,
   parameter int LocalCapacity = smw_pkg::STACK_DEPTH_DEF,
   parameter int GlobalDepth   = smw_pkg::GLOBAL_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [1:0]  req_thread_index,
   input  logic [63:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_popped_address,
   output logic        rsp_pop_found,
   output logic        rsp_all_empty,
   output logic        rsp_spill_dropped,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data
);
   import smw_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [2:0]    active_ff;
   logic [63:0]   res_address;
   logic          res_all_empty, res_dropped;

   // hold the register; writes must only arrive while idle, which the block itself does not enforce
   always_ff @(posedge clock) begin
      if (reset) active_ff <= ACTIVE_RESET;
      else if (csr_valid && csr_ready) active_ff <= csr_data;
   end
   assign csr_ready = 1'b1;

   smw_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_command,
      .rsp_valid, .rsp_ready, .cmd, .status
   );

   smw_datapath #(
      .NumThreads(NumThreads), .LocalCapacity(LocalCapacity),
      .GlobalDepth(GlobalDepth)
   ) u_dp (
      .clock, .reset, .cmd, .status, .active_threads(active_ff),
      .req_command, .req_thread_index, .req_address,
      .res_address, .res_all_empty, .res_dropped
   );

   // push results carry a zero address, pop results never flag a drop
   assign rsp_popped_address = res_address;
   assign rsp_pop_found      = (res_address != '0);
   assign rsp_all_empty      = res_all_empty;
   assign rsp_spill_dropped  = res_dropped;

endmodule
